@@ rtl/core/ksed_pkg.sv @@
// shared types, constants and lookup tables of the keyed string entry decoder
package ksed_pkg;

	// default sizes
	localparam int MAX_PAYLOAD_DEF = 8192;
	localparam int OUT_MAX_DEF     = 4096;

	// entry layout and unpack widths
	localparam int HDR_LEN = 6;
	localparam int POS_W   = 20;
	localparam int BIDX_W  = 18;

	localparam logic [15:0] CODE_LO   = 16'h0020;
	localparam logic [7:0]  RAW_WIDTH = 8'h10;
	localparam logic [7:0]  MAX_WIDTH = 8'h10;

	// key mix round constants
	localparam logic [31:0] MIX_KA     = 32'h9fb498b3;
	localparam logic [31:0] MIX_KB     = 32'h66b0cd0d;
	localparam logic [31:0] MIX_F_MASK = 32'h22222222;
	localparam logic [31:0] MIX_F_KEEP = 32'h7bf36ae2;
	localparam logic [31:0] MIX_KC     = 32'hf33d5697;
	localparam logic [31:0] MIX_G      = 32'h59d148c0;
	localparam logic [31:0] MIX_KD     = 32'hd675e47b;
	localparam logic [31:0] MIX_KE     = 32'hb453c259;

	// short code table for codes below CODE_LO
	localparam logic [15:0] CODE_TABLE [32] = '{
		16'h0000, 16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
		16'h0073, 16'h0074, 16'h0072, 16'h006E, 16'h0075, 16'h006D, 16'h0028, 16'h0029,
		16'h005B, 16'h005D, 16'h003C, 16'h003E, 16'h0025, 16'h0023, 16'h002F, 16'h003A,
		16'h002D, 16'h0027, 16'h0022, 16'h0020, 16'h002C, 16'h002E, 16'h0021, 16'h000A
	};

	// command beat
	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [63:0] entry_key;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] char_count;
		logic [15:0] character;
		logic        char_valid;
		logic        end_of_string;
	} res_t;

	// control into the rc4 unit
	typedef struct packed {
		logic        sched;
		logic        next;
		logic [63:0] key;
	} rc4_req_t;

	// status out of the rc4 unit
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] ks;
	} rc4_rsp_t;

	function automatic logic [31:0] rot5(input logic [31:0] v);
		return {v[26:0], v[31:27]};
	endfunction

	function automatic logic [31:0] rot30(input logic [31:0] v);
		return {v[1:0], v[31:2]};
	endfunction

	function automatic logic [15:0] code_lut(input logic [4:0] idx);
		return CODE_TABLE[idx];
	endfunction

endpackage

@@ rtl/core/ksed_ram.sv @@
// generic single write, single read ram with registered read data
module ksed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/ksed_rc4.sv @@
// rc4 unit: key mix, s-box fill, key schedule and keystream over one s-box ram
module ksed_rc4 import ksed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rc4_req_t req,
	output rc4_rsp_t rsp
);

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_FILL = 3'd1;
	localparam logic [2:0] R_RD_X = 3'd2;
	localparam logic [2:0] R_RD_Y = 3'd3;
	localparam logic [2:0] R_WR_X = 3'd4;
	localparam logic [2:0] R_WR_Y = 3'd5;
	localparam logic [2:0] R_RD_T = 3'd6;
	localparam logic [2:0] R_OUT  = 3'd7;

	// key mix steps, spread over the first cycles of the fill
	localparam logic [7:0] MIX_A = 8'd0;
	localparam logic [7:0] MIX_B = 8'd1;
	localparam logic [7:0] MIX_C = 8'd2;
	localparam logic [7:0] MIX_D = 8'd3;
	localparam logic [7:0] MIX_E = 8'd4;
	localparam logic [7:0] MIX_W = 8'd5;

	localparam logic [4:0] RK_LAST = 5'd19;

	logic [2:0]   st_q;
	logic         ksa_q;
	logic [7:0]   x_q, y_q, sx_q, sy_q;
	logic [4:0]   r20_q;
	logic [63:0]  key_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] rk_q;

	logic         we;
	logic [7:0]   waddr, wdata, raddr, rdata;
	logic [7:0]   y_new, rk_byte;
	logic [31:0]  lo, hi, a30, b30, fa, g, h;

	ksed_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// key mix terms
	assign lo  = key_q[31:0];
	assign hi  = key_q[63:32];
	assign a30 = rot30(a_q);
	assign b30 = rot30(b_q);
	assign fa  = ~(a_q & MIX_F_MASK) & MIX_F_KEEP;
	assign g   = ((a30 ^ MIX_G) & b_q) ^ MIX_G;
	assign h   = ((a30 ^ b30) & c_q) ^ a30;

	assign rk_byte = rk_q[{r20_q, 3'b000} +: 8];
	assign y_new   = y_q + rdata + (ksa_q ? rk_byte : 8'h00);

	// s-box ram port control
	always_comb begin
		we    = 1'b0;
		waddr = x_q;
		wdata = x_q;
		raddr = x_q;
		unique case (st_q)
			R_FILL: begin
				we = 1'b1;
			end
			R_RD_X: begin
				raddr = ksa_q ? x_q : x_q + 8'd1;
			end
			R_RD_Y: begin
				raddr = y_new;
			end
			R_WR_X: begin
				we    = 1'b1;
				wdata = rdata;
			end
			R_WR_Y: begin
				we    = 1'b1;
				waddr = y_q;
				wdata = sx_q;
			end
			R_RD_T: begin
				raddr = sx_q + sy_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp.busy = (st_q != R_IDLE);
	assign rsp.done = (st_q == R_OUT) || (st_q == R_WR_Y && ksa_q && x_q == 8'hFF);
	assign rsp.ks   = rdata;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= R_IDLE;
			ksa_q <= 1'b0;
			x_q   <= '0;
			y_q   <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			r20_q <= '0;
			key_q <= '0;
			a_q   <= '0;
			b_q   <= '0;
			c_q   <= '0;
			d_q   <= '0;
			e_q   <= '0;
			rk_q  <= '0;
		end else begin
			unique case (st_q)
				R_IDLE: begin
					if (req.sched) begin
						key_q <= req.key;
						ksa_q <= 1'b1;
						x_q   <= '0;
						st_q  <= R_FILL;
					end else if (req.next) begin
						ksa_q <= 1'b0;
						st_q  <= R_RD_X;
					end
				end
				R_FILL: begin
					case (x_q)
						MIX_A: a_q <= lo + MIX_KA;
						MIX_B: b_q <= hi + MIX_KB + rot5(a_q);
						MIX_C: c_q <= rot5(b_q) + lo + fa + MIX_KC;
						MIX_D: d_q <= hi + rot5(c_q) + g + MIX_KD;
						MIX_E: e_q <= h + lo + rot5(d_q) + MIX_KE + lo;
						MIX_W: rk_q <= {a30 + lo, b30 + hi, lo + rot30(c_q), hi + d_q, e_q};
						default: begin
						end
					endcase
					x_q <= x_q + 8'd1;
					if (x_q == 8'hFF) begin
						y_q   <= '0;
						r20_q <= '0;
						st_q  <= R_RD_X;
					end
				end
				R_RD_X: begin
					if (!ksa_q) begin
						x_q <= x_q + 8'd1;
					end
					st_q <= R_RD_Y;
				end
				R_RD_Y: begin
					sx_q <= rdata;
					y_q  <= y_new;
					st_q <= R_WR_X;
				end
				R_WR_X: begin
					sy_q <= rdata;
					st_q <= R_WR_Y;
				end
				R_WR_Y: begin
					if (ksa_q) begin
						x_q   <= x_q + 8'd1;
						r20_q <= (r20_q == RK_LAST) ? 5'd0 : r20_q + 5'd1;
						if (x_q == 8'hFF) begin
							y_q   <= '0;
							ksa_q <= 1'b0;
							st_q  <= R_IDLE;
						end else begin
							st_q <= R_RD_X;
						end
					end else begin
						st_q <= R_RD_T;
					end
				end
				R_RD_T: begin
					st_q <= R_OUT;
				end
				R_OUT: begin
					st_q <= R_IDLE;
				end
				default: begin
					st_q <= R_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/ksed_char_dec.sv @@
// character decode from a three byte window: raw words or packed codes
module ksed_char_dec import ksed_pkg::*; (
	input  logic [23:0] window,
	input  logic [2:0]  shift,
	input  logic [7:0]  width,
	input  logic [15:0] base,
	input  logic        raw,
	output logic [15:0] character
);

	logic [23:0] shifted;
	logic [16:0] mask;
	logic [15:0] code;

	// extract the code at the bit offset
	assign shifted = window >> shift;
	assign mask    = (17'd1 << width[4:0]) - 17'd1;
	assign code    = shifted[15:0] & mask[15:0];

	// map the code to a character
	always_comb begin
		if (raw) begin
			character = window[15:0];
		end else if (code == 16'h0000) begin
			character = 16'h0000;
		end else if (code < CODE_LO) begin
			character = code_lut(code[4:0]);
		end else begin
			character = base - CODE_LO + code;
		end
	end

endmodule

@@ rtl/core/keyed_rc4_string_entry_decoder.sv @@
// top level: entry loading, status check, character scan and fetch
//
//  channel | direction | handshake          | beat
//  cmd     | in        | cmd_valid/cmd_stall | command, data byte, last flag, key
//  res     | out       | res_valid/res_stall | status, count, character, flags
//
// header and plain payload bytes are taken directly; a keyed payload byte waits for its
// keystream byte, built from the reads and swap writes on the single s-box ram.
// the sixth byte of a keyed entry runs the s-box fill and key schedule.
// the last byte scans the payload ram one character after another; a fetch reads and decodes one character.
// reset leaves no entry loaded; the s-box is rebuilt for each keyed entry.
// a stalled result is held in its output register while the next beat is taken.
module keyed_rc4_string_entry_decoder import ksed_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int OUT_MAX     = OUT_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW    = $clog2(MAX_PAYLOAD);
	localparam int CNT_W = $clog2(OUT_MAX + 1);

	localparam logic       CMD_PUSH = 1'b0;

	localparam logic [1:0] EST_NONE = 2'd0;
	localparam logic [1:0] EST_LOAD = 2'd1;
	localparam logic [1:0] EST_OK   = 2'd2;
	localparam logic [1:0] EST_ERR  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MALFORM  = 2'd1;
	localparam logic [1:0] ST_WIDTH    = 2'd2;
	localparam logic [1:0] ST_NO_ENTRY = 2'd3;

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_SCHED = 3'd1;
	localparam logic [2:0] T_KS    = 3'd2;
	localparam logic [2:0] T_CHECK = 3'd3;
	localparam logic [2:0] T_SCAN  = 3'd4;
	localparam logic [2:0] T_RD    = 3'd5;
	localparam logic [2:0] T_DEC   = 3'd6;
	localparam logic [2:0] T_EMIT  = 3'd7;

	localparam logic [15:0] HDR_LEN_LO  = 16'd0;
	localparam logic [15:0] HDR_LEN_HI  = 16'd1;
	localparam logic [15:0] HDR_BASE_LO = 16'd2;
	localparam logic [15:0] HDR_BASE_HI = 16'd3;
	localparam logic [15:0] HDR_WIDTH   = 16'd4;
	localparam logic [15:0] HDR_SPARE   = 16'd5;

	localparam logic [1:0] RD_LAST = 2'd3;

	logic [2:0]       tst_q;
	logic [1:0]       est_q, status_q;
	logic [15:0]      bseen_q, total_q, base_q, wpos_q;
	logic [7:0]       width_q, byte_q;
	logic [63:0]      key_q;
	logic [CNT_W-1:0] ctotal_q, n_q;
	logic [POS_W-1:0] pos_q;
	logic             scan_q, last_q, wr_ok_q, rdv_q, res_valid_q;
	logic [1:0]       k_q;
	logic [7:0]       b_q [3];
	res_t             pend_q, res_q;

	logic              accept, push, new_entry, keyed, raw, fits, wr_ok, idx_ok, bad;
	logic [15:0]       bpos, wpos, pl;
	logic [1:0]        stat;
	logic [BIDX_W-1:0] idx;
	logic [15:0]       ch;
	logic              pay_we;
	logic [AW-1:0]     pay_waddr;
	logic [7:0]        pay_wdata, pay_rdata;
	rc4_req_t          rreq;
	rc4_rsp_t          rrsp;

	// beat acceptance and push position
	assign accept    = cmd_valid && (tst_q == T_IDLE);
	assign push      = (cmd.command == CMD_PUSH);
	assign new_entry = (est_q != EST_LOAD);
	assign bpos      = new_entry ? 16'd0 : bseen_q;
	assign wpos      = bpos - 16'(HDR_LEN);
	assign wr_ok     = 32'(wpos) < 32'(MAX_PAYLOAD);
	assign keyed     = (key_q != 64'd0);

	// entry geometry and status
	assign pl   = total_q - 16'(HDR_LEN);
	assign raw  = (base_q == 16'h0000) && (width_q == RAW_WIDTH);
	assign bad  = (bseen_q < 16'(HDR_LEN)) || (total_q < 16'(HDR_LEN)) || (total_q > bseen_q)
		|| (pl == 16'd0) || (32'(pl) > 32'(MAX_PAYLOAD));
	assign stat = bad ? ST_MALFORM : ((!raw && width_q > MAX_WIDTH) ? ST_WIDTH : ST_OK);

	// room for one more character
	assign fits = (width_q != 8'd0)
		&& ((pos_q + POS_W'(width_q)) <= POS_W'({pl, 3'b000}))
		&& (32'(n_q) < 32'(OUT_MAX));

	// payload byte index for the current read
	assign idx    = {1'b0, pos_q[POS_W-1:3]} + BIDX_W'(k_q);
	assign idx_ok = (idx < BIDX_W'(pl)) && (32'(idx) < 32'(MAX_PAYLOAD));

	// rc4 requests
	assign rreq.sched = accept && push && (bpos == HDR_SPARE) && keyed;
	assign rreq.next  = accept && push && (bpos >= 16'(HDR_LEN)) && keyed;
	assign rreq.key   = key_q;

	ksed_rc4 u_rc4 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	// payload ram write: plain bytes directly, keyed bytes once the keystream is back
	assign pay_we = (accept && push && (bpos >= 16'(HDR_LEN)) && !keyed && wr_ok)
		|| (tst_q == T_KS && rrsp.done && wr_ok_q);
	assign pay_waddr = (tst_q == T_KS) ? wpos_q[AW-1:0] : wpos[AW-1:0];
	assign pay_wdata = (tst_q == T_KS) ? (byte_q ^ rrsp.ks) : cmd.data_byte;

	ksed_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (idx[AW-1:0]),
		.rdata (pay_rdata)
	);

	ksed_char_dec u_dec (
		.window    ({b_q[2], b_q[1], b_q[0]}),
		.shift     (pos_q[2:0]),
		.width     (width_q),
		.base      (base_q),
		.raw       (raw),
		.character (ch)
	);

	assign cmd_stall = (tst_q != T_IDLE);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tst_q    <= T_IDLE;
			est_q    <= EST_NONE;
			status_q <= ST_OK;
			bseen_q  <= '0;
			total_q  <= '0;
			base_q   <= '0;
			width_q  <= '0;
			key_q    <= '0;
			ctotal_q <= '0;
			n_q      <= '0;
			pos_q    <= '0;
			scan_q   <= 1'b0;
			last_q   <= 1'b0;
			wr_ok_q  <= 1'b0;
			rdv_q    <= 1'b0;
			k_q      <= '0;
			byte_q   <= '0;
			wpos_q   <= '0;
			b_q      <= '{default: '0};
			pend_q   <= '0;
		end else begin
			unique case (tst_q)
				T_IDLE: begin
					if (accept && push) begin
						last_q  <= cmd.last_byte;
						byte_q  <= cmd.data_byte;
						wpos_q  <= wpos;
						wr_ok_q <= wr_ok;
						if (new_entry) begin
							est_q    <= EST_LOAD;
							base_q   <= '0;
							width_q  <= '0;
							key_q    <= cmd.entry_key;
							ctotal_q <= '0;
							n_q      <= '0;
							pos_q    <= '0;
						end
						bseen_q <= (bpos == 16'hFFFF) ? bpos : bpos + 16'd1;
						case (bpos)
							HDR_LEN_LO:  total_q <= {8'h00, cmd.data_byte};
							HDR_LEN_HI:  total_q[15:8] <= cmd.data_byte;
							HDR_BASE_LO: base_q[7:0] <= cmd.data_byte;
							HDR_BASE_HI: base_q[15:8] <= cmd.data_byte;
							HDR_WIDTH:   width_q <= cmd.data_byte;
							default: begin
							end
						endcase
						if (bpos == HDR_SPARE && keyed) begin
							tst_q <= T_SCHED;
						end else if (bpos >= 16'(HDR_LEN) && keyed) begin
							tst_q <= T_KS;
						end else if (cmd.last_byte) begin
							tst_q <= T_CHECK;
						end
					end else if (accept) begin
						if (est_q == EST_NONE || est_q == EST_LOAD) begin
							pend_q <= '{status: ST_NO_ENTRY, char_count: 13'd0, character: 16'h0,
								char_valid: 1'b0, end_of_string: 1'b1};
							tst_q  <= T_EMIT;
						end else if (est_q == EST_ERR) begin
							pend_q <= '{status: status_q, char_count: 13'd0, character: 16'h0,
								char_valid: 1'b0, end_of_string: 1'b1};
							tst_q  <= T_EMIT;
						end else if (n_q >= ctotal_q) begin
							pend_q <= '{status: ST_OK, char_count: 13'(ctotal_q),
								character: 16'h0, char_valid: 1'b0, end_of_string: 1'b1};
							tst_q  <= T_EMIT;
						end else begin
							scan_q <= 1'b0;
							k_q    <= '0;
							tst_q  <= T_RD;
						end
					end
				end
				T_SCHED, T_KS: begin
					if (rrsp.done) begin
						tst_q <= last_q ? T_CHECK : T_IDLE;
					end
				end
				T_CHECK: begin
					status_q <= stat;
					if (stat != ST_OK) begin
						est_q    <= EST_ERR;
						ctotal_q <= '0;
						pend_q   <= '{status: stat, char_count: 13'd0, character: 16'h0,
							char_valid: 1'b0, end_of_string: 1'b1};
						tst_q    <= T_EMIT;
					end else begin
						est_q  <= EST_OK;
						n_q    <= '0;
						pos_q  <= '0;
						scan_q <= 1'b1;
						tst_q  <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (!fits) begin
						ctotal_q <= n_q;
						pend_q   <= '{status: ST_OK, char_count: 13'(n_q), character: 16'h0,
							char_valid: 1'b0, end_of_string: (n_q == '0)};
						n_q      <= '0;
						pos_q    <= '0;
						tst_q    <= T_EMIT;
					end else begin
						k_q   <= '0;
						tst_q <= T_RD;
					end
				end
				T_RD: begin
					// reads issue one per cycle, data lands in the next cycle
					rdv_q <= idx_ok;
					if (k_q != 2'd0) begin
						b_q[k_q - 2'd1] <= rdv_q ? pay_rdata : 8'h00;
					end
					k_q <= k_q + 2'd1;
					if (k_q == RD_LAST) begin
						tst_q <= T_DEC;
					end
				end
				T_DEC: begin
					if (scan_q && ch == 16'h0000) begin
						ctotal_q <= n_q;
						pend_q   <= '{status: ST_OK, char_count: 13'(n_q), character: 16'h0,
							char_valid: 1'b0, end_of_string: (n_q == '0)};
						n_q      <= '0;
						pos_q    <= '0;
						tst_q    <= T_EMIT;
					end else if (scan_q) begin
						n_q   <= n_q + CNT_W'(1);
						pos_q <= pos_q + POS_W'(width_q);
						tst_q <= T_SCAN;
					end else begin
						pend_q <= '{status: ST_OK, char_count: 13'(ctotal_q), character: ch,
							char_valid: 1'b1, end_of_string: ((n_q + CNT_W'(1)) >= ctotal_q)};
						n_q    <= n_q + CNT_W'(1);
						pos_q  <= pos_q + POS_W'(width_q);
						tst_q  <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (!res_valid_q || !res_stall) begin
						tst_q <= T_IDLE;
					end
				end
				default: begin
					tst_q <= T_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tst_q == T_EMIT && (!res_valid_q || !res_stall)) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (tst_q == T_EMIT && (!res_valid_q || !res_stall)) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// rc4 unit is idle whenever a new beat can be taken
	a_rc4_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tst_q == T_IDLE |-> !rrsp.busy)
		else $error("rc4 unit busy while idle");

	// fetch position never runs past the character count
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		est_q == EST_OK && tst_q == T_IDLE |-> n_q <= ctotal_q)
		else $error("fetch index beyond character count");

	// a decoded character only comes with a good status
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.char_valid |-> res.status == ST_OK)
		else $error("character on an entry in error");

	// a new result only follows the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(tst_q) == T_EMIT)
		else $error("result without emit step");

endmodule
